@@ sv/lidar_scan_packet_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// lidar scan packet decoder assertion macros
// checks on the decoder's internal logic, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_PACKET_DECODER_DEFINES_SVH
`define LIDAR_SCAN_PACKET_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// implication checked on every rising clock edge, suspended while in reset
`define LSPD_ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("lspd assertion failed");
// next-cycle implication, suspended while in reset
`define LSPD_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("lspd assertion failed");
`else
`define LSPD_ASSERT_IMPL(label, cond, expr)
`define LSPD_ASSERT_NEXT(label, cond, expr)
`endif

`endif

@@ sv/lspd_pkg.sv @@
// ----------------------------------------------------------------------------
// lspd_pkg
// shared types and constants of the lidar scan packet decoder
// ----------------------------------------------------------------------------
package lspd_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [15:0] RANGE_MAX_RST  = 16'd48000;
    localparam logic [15:0] RANGE_MIN_RST  = 16'd600;
    localparam logic [8:0]  SCAN_LIMIT_RST = 9'd360;

    localparam logic [14:0] ANGLE_MAX_Q6 = 15'd23040;
    localparam logic [14:0] ANGLE_HALF   = 15'd32;
    localparam logic [8:0]  COUNT_MAX    = 9'd511;

    // bytes of the current packet already held
    localparam logic [2:0] POS_FIRST  = 3'd0;
    localparam logic [2:0] POS_SECOND = 3'd1;
    localparam logic [2:0] POS_THIRD  = 3'd2;
    localparam logic [2:0] POS_FOURTH = 3'd3;
    localparam logic [2:0] POS_LAST   = 3'd4;

    typedef enum logic [1:0] {
        REG_RANGE_MAX  = 2'd0,
        REG_RANGE_MIN  = 2'd1,
        REG_SCAN_LIMIT = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_DISCARD = 2'd0,
        ACT_STORE   = 2'd1,
        ACT_CLOSE   = 2'd2
    } action_t;

    typedef struct packed {
        logic [15:0] range_max_raw;
        logic [15:0] range_min_raw;
        logic [8:0]  scan_limit;
    } cfg_t;

endpackage

@@ sv/lspd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lspd_cfg_regs
// apb register file holding the range limits and the scan measurement limit
// ----------------------------------------------------------------------------
module lspd_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lspd_pkg::ADDR_W-1:0] paddr,
    input  logic [lspd_pkg::DATA_W-1:0] pwdata,
    output logic [lspd_pkg::DATA_W-1:0] prdata,
    output lspd_pkg::cfg_t             cfg
);
    import lspd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_RANGE_MAX:  cfg_next.range_max_raw = pwdata[15:0];
                REG_RANGE_MIN:  cfg_next.range_min_raw = pwdata[15:0];
                REG_SCAN_LIMIT: cfg_next.scan_limit    = pwdata[8:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RANGE_MAX:  prdata = {16'd0, cfg_reg.range_max_raw};
            REG_RANGE_MIN:  prdata = {16'd0, cfg_reg.range_min_raw};
            REG_SCAN_LIMIT: prdata = {23'd0, cfg_reg.scan_limit};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_max_raw <= RANGE_MAX_RST;
            cfg_reg.range_min_raw <= RANGE_MIN_RST;
            cfg_reg.scan_limit    <= SCAN_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/lidar_scan_packet_decoder.sv @@
// ----------------------------------------------------------------------------
// lidar_scan_packet_decoder
// assembles 5-byte lidar scan packets from serial bytes and classifies them
// ----------------------------------------------------------------------------
// result: the result of a packet is registered and valid in the cycle after its fifth byte
// throughput: one byte per cycle; the result register frees in the cycle it is
// taken, so bytes keep flowing while m_ready is high
// reset (aresetn low, synchronous): hunting restarts at the first pair byte,
// the measurement count clears and the registers return to their defaults
// ----------------------------------------------------------------------------
`include "lidar_scan_packet_decoder_defines.svh"

module lidar_scan_packet_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    // byte input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    // decoded packet
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_action,
    output logic [8:0]                  m_angle_bin,
    output logic [15:0]                 m_distance_raw,
    output logic [5:0]                  m_quality,
    output logic                        m_start_flag,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lspd_pkg::ADDR_W-1:0] paddr,
    input  logic [lspd_pkg::DATA_W-1:0] pwdata,
    output logic [lspd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import lspd_pkg::*;

    cfg_t cfg;

    logic [2:0]  pos_reg, pos_next;
    logic [31:0] pkt_reg, pkt_next;
    logic [8:0]  count_reg, count_next;

    logic        m_valid_reg, m_valid_next;
    action_t     act_reg, act_next;
    logic [8:0]  bin_reg, bin_next;
    logic [15:0] dist_reg, dist_next;
    logic [5:0]  qual_reg, qual_next;
    logic        flag_reg, flag_next;

    logic        accept;
    logic        pkt_done;
    logic [7:0]  b0;
    logic [14:0] angle_q6;
    logic [14:0] angle_round;
    logic        angle_ok;
    logic        in_range;
    logic        do_close;
    logic        do_store;

    lspd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready  = 1'b1;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign pkt_done = (pos_reg == POS_LAST);

    // packet decode, last byte is the high distance byte
    // rounding can only wrap for angles that are out of range anyway
    assign b0          = pkt_reg[7:0];
    assign angle_q6    = {pkt_reg[23:16], pkt_reg[15:9]};
    assign angle_round = angle_q6 + ANGLE_HALF;
    assign angle_ok    = (angle_q6 <= ANGLE_MAX_Q6);
    assign dist_next   = {s_rx_byte, pkt_reg[31:24]};
    assign qual_next   = b0[7:2];
    assign flag_next   = b0[0];
    assign bin_next    = angle_ok ? angle_round[14:6] : 9'd0;

    assign in_range = (dist_next <= cfg.range_max_raw);
    assign do_close = angle_ok &&
                      ((flag_next && in_range) || (count_reg >= cfg.scan_limit));
    assign do_store = angle_ok && !do_close && !flag_next && (dist_next != 16'd0) &&
                      in_range && (dist_next >= cfg.range_min_raw);

    always_comb begin
        if (do_close) begin
            act_next = ACT_CLOSE;
        end else if (do_store) begin
            act_next = ACT_STORE;
        end else begin
            act_next = ACT_DISCARD;
        end
    end

    // byte assembly and pair hunting
    always_comb begin
        pos_next   = pos_reg;
        pkt_next   = pkt_reg;
        count_next = count_reg;
        if (accept) begin
            unique case (pos_reg)
                POS_FIRST: begin
                    pkt_next[7:0] = s_rx_byte;
                    pos_next      = POS_SECOND;
                end
                POS_SECOND: begin
                    pkt_next[15:8] = s_rx_byte;
                    // check bit set and start bit differs from its inverse
                    pos_next = (s_rx_byte[0] && (b0[0] ^ b0[1])) ? POS_THIRD : POS_FIRST;
                end
                POS_THIRD: begin
                    pkt_next[23:16] = s_rx_byte;
                    pos_next        = POS_FOURTH;
                end
                POS_FOURTH: begin
                    pkt_next[31:24] = s_rx_byte;
                    pos_next        = POS_LAST;
                end
                POS_LAST: begin
                    pos_next = POS_FIRST;
                    if (do_close) begin
                        count_next = 9'd0;
                    end else if (do_store && (count_reg != COUNT_MAX)) begin
                        count_next = count_reg + 9'd1;
                    end
                end
                default: begin
                    // out-of-range position restarts the hunt with this byte
                    pkt_next[7:0] = s_rx_byte;
                    pos_next      = POS_SECOND;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (accept && pkt_done) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_FIRST;
            pkt_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            pkt_reg     <= pkt_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pkt_done) begin
            act_reg  <= act_next;
            bin_reg  <= bin_next;
            dist_reg <= dist_next;
            qual_reg <= qual_next;
            flag_reg <= flag_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_action       = act_reg;
    assign m_angle_bin    = bin_reg;
    assign m_distance_raw = dist_reg;
    assign m_quality      = qual_reg;
    assign m_start_flag   = flag_reg;

    // only the fifth byte of a packet yields a request
    `LSPD_ASSERT_NEXT(a_no_result_mid_packet, accept && !pkt_done && m_ready, !m_valid_reg)
    // closing a scan clears the measurement count
    `LSPD_ASSERT_NEXT(a_close_clears_count, accept && pkt_done && do_close, count_reg == 9'd0)
    // a stored measurement advances the count unless saturated
    `LSPD_ASSERT_NEXT(a_store_counts,
        accept && pkt_done && do_store && (count_reg != COUNT_MAX),
        count_reg == $past(count_reg) + 9'd1)
    // the hunt never leaves the five packet positions
    `LSPD_ASSERT_IMPL(a_pos_bounded, 1'b1, pos_reg <= POS_LAST)

endmodule
